/* src/dedd_pkg.sv */
// Shared types, constants and register map for the dead end detector.
// Used by every module of the block; it depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dedd_pkg;

  // Size of the point table, used as the default of the top-level parameter.
  localparam int MAX_ENTRIES_DEF = 128;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Field widths.
  localparam int PROX_W   = 12;
  localparam int POS_W    = 16;
  localparam int RADIUS_W = 16;
  localparam int COUNT_W  = 8;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 16;

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_FRONT_THR = 2'd0,
    REG_SIDE_THR  = 2'd1,
    REG_RADIUS    = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_e;

  localparam logic [PROX_W-1:0]   FRONT_THR_RST = 12'd80;
  localparam logic [PROX_W-1:0]   SIDE_THR_RST  = 12'd50;
  localparam logic [RADIUS_W-1:0] RADIUS_RST    = 16'd100;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } point_t;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    logic   dead;
    point_t pos;
  } item_t;

  typedef struct packed {
    logic                trapped;
    logic                recorded;
    logic                duplicate;
    logic                table_full;
    logic [COUNT_W-1:0]  stored_count;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT
  } back_state_e;

endpackage

`default_nettype wire

/* src/dedd_front.sv */
// Front end: configuration registers, input handshake and dead end classification.
// Depends on dedd_pkg; pushes classified words into dedd_fifo.
`timescale 1ns / 1ps
`default_nettype none

module dedd_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // APB-style configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dedd_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [dedd_pkg::PDATA_W-1:0]      pwdata,
  output logic      [dedd_pkg::PDATA_W-1:0]      prdata,
  output logic                                   pready,
  // Input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // front_prox[11:0], left_prox[23:12], right_prox[35:24], pos_x[51:36],
  // pos_y[67:52], pos_z[83:68], zero pad[87:84]
  input  wire logic [dedd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // Towards the queue
  input  wire logic                              q_full_i,
  output logic                                   q_push_o,
  output dedd_pkg::item_t                        q_item_o,
  // Radius for the back end
  output logic      [dedd_pkg::RADIUS_W-1:0]     radius_o
);

  logic [dedd_pkg::PROX_W-1:0]   front_thr_q, front_thr_d;
  logic [dedd_pkg::PROX_W-1:0]   side_thr_q,  side_thr_d;
  logic [dedd_pkg::RADIUS_W-1:0] radius_q,    radius_d;
  dedd_pkg::reg_idx_e            reg_idx;
  logic                          wr_en;

  logic [dedd_pkg::PROX_W-1:0] front_prox, left_prox, right_prox;

  assign pready  = 1'b1;
  assign reg_idx = dedd_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    front_thr_d = front_thr_q;
    side_thr_d  = side_thr_q;
    radius_d    = radius_q;
    prdata      = '0;
    case (reg_idx)
      dedd_pkg::REG_FRONT_THR: begin
        if (wr_en) front_thr_d = pwdata[dedd_pkg::PROX_W-1:0];
        prdata = {20'd0, front_thr_q};
      end
      dedd_pkg::REG_SIDE_THR: begin
        if (wr_en) side_thr_d = pwdata[dedd_pkg::PROX_W-1:0];
        prdata = {20'd0, side_thr_q};
      end
      dedd_pkg::REG_RADIUS: begin
        if (wr_en) radius_d = pwdata[dedd_pkg::RADIUS_W-1:0];
        prdata = {16'd0, radius_q};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_thr_q <= dedd_pkg::FRONT_THR_RST;
      side_thr_q  <= dedd_pkg::SIDE_THR_RST;
      radius_q    <= dedd_pkg::RADIUS_RST;
    end else begin
      front_thr_q <= front_thr_d;
      side_thr_q  <= side_thr_d;
      radius_q    <= radius_d;
    end
  end

  assign radius_o = radius_q;

  // Unpack the word and classify it on the way into the queue.
  assign front_prox = s_axis_tdata[11:0];
  assign left_prox  = s_axis_tdata[23:12];
  assign right_prox = s_axis_tdata[35:24];

  assign s_axis_tready    = !q_full_i;
  assign q_push_o         = s_axis_tvalid && s_axis_tready;
  assign q_item_o.dead    = (front_prox > front_thr_q) && (left_prox > side_thr_q)
                            && (right_prox > side_thr_q);
  assign q_item_o.pos.x   = s_axis_tdata[51:36];
  assign q_item_o.pos.y   = s_axis_tdata[67:52];
  assign q_item_o.pos.z   = s_axis_tdata[83:68];

endmodule

`default_nettype wire

/* src/dedd_fifo.sv */
// Short queue of classified words between the front and the back end.
// Depends on dedd_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none

module dedd_fifo #(
  parameter int DEPTH = dedd_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire dedd_pkg::item_t push_item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output dedd_pkg::item_t      pop_item_o,
  output logic                 empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dedd_pkg::item_t slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] fill_q,   fill_d;
  logic             do_push, do_pop;

  assign full_o     = (fill_q == CNT_W'(DEPTH));
  assign empty_o    = (fill_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

/* src/dedd_back.sv */
// Back end: point table, pipelined duplicate scan and the output register.
// Depends on dedd_pkg; takes words from dedd_fifo.
`timescale 1ns / 1ps
`default_nettype none

module dedd_back #(
  parameter int MAX_ENTRIES = dedd_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [dedd_pkg::RADIUS_W-1:0]     radius_i,
  // From the queue
  input  wire logic                              q_empty_i,
  input  wire dedd_pkg::item_t                   q_item_i,
  output logic                                   q_pop_o,
  // Result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // trapped[0], recorded[1], duplicate[2], table_full[3], stored_count[11:4],
  // zero pad[15:12]
  output logic      [dedd_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  dedd_pkg::back_state_e state_q, state_d;

  dedd_pkg::item_t  item_q;
  logic [31:0]      r2_q;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             dup_q, dup_d;
  logic             v1_q, v2_q, v3_q;
  logic             issue;

  dedd_pkg::point_t mem [MAX_ENTRIES];
  dedd_pkg::point_t rdata_q;
  logic             wr_en;

  logic [15:0] ad_q [3];
  logic [15:0] ad_d [3];
  logic [31:0] sq_q [3];
  logic [33:0] dist2;
  logic        hit;

  logic             out_free;
  logic             load_out;
  dedd_pkg::result_t out_q, out_d;
  logic             out_valid_q;
  logic             rec, full;
  logic [CNT_W+7:0] cnt_ext;

  logic signed [dedd_pkg::POS_W:0] diff [3];
  logic        [dedd_pkg::POS_W:0] neg  [3];

  // Absolute coordinate differences; they always fit in 16 bits unsigned.
  always_comb begin
    diff[0] = {item_q.pos.x[15], item_q.pos.x} - {rdata_q.x[15], rdata_q.x};
    diff[1] = {item_q.pos.y[15], item_q.pos.y} - {rdata_q.y[15], rdata_q.y};
    diff[2] = {item_q.pos.z[15], item_q.pos.z} - {rdata_q.z[15], rdata_q.z};
    for (int k = 0; k < 3; k++) begin
      neg[k]  = 17'd0 - diff[k];
      ad_d[k] = diff[k][16] ? neg[k][15:0] : diff[k][15:0];
    end
  end

  assign dist2 = {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
  assign hit   = v3_q && (dist2 < {2'b00, r2_q});
  assign issue = (state_q == dedd_pkg::BK_SCAN) && (rd_idx_q < cnt_q);

  assign out_free = !out_valid_q || m_axis_tready;
  assign rec      = item_q.dead && !dup_q && (cnt_q < CNT_W'(MAX_ENTRIES));
  assign full     = item_q.dead && !dup_q && !(cnt_q < CNT_W'(MAX_ENTRIES));

  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    dup_d    = dup_q;
    cnt_d    = cnt_q;
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    wr_en    = 1'b0;
    cnt_ext  = '0;
    out_d    = out_q;
    case (state_q)
      dedd_pkg::BK_IDLE: begin
        rd_idx_d = '0;
        dup_d    = 1'b0;
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = q_item_i.dead ? dedd_pkg::BK_SCAN : dedd_pkg::BK_EMIT;
        end
      end
      dedd_pkg::BK_SCAN: begin
        if (issue) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (hit) begin
          dup_d   = 1'b1;
          state_d = dedd_pkg::BK_EMIT;
        end else if (!issue && !v1_q && !v2_q && !v3_q) begin
          state_d = dedd_pkg::BK_EMIT;
        end
      end
      dedd_pkg::BK_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          wr_en    = rec;
          cnt_d    = rec ? cnt_q + 1'b1 : cnt_q;
          cnt_ext  = {8'd0, cnt_d};
          out_d.trapped      = item_q.dead;
          out_d.recorded     = rec;
          out_d.duplicate    = dup_q;
          out_d.table_full   = full;
          out_d.stored_count = cnt_ext[7:0];
          state_d  = dedd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = dedd_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dedd_pkg::BK_IDLE;
      rd_idx_q    <= '0;
      cnt_q       <= '0;
      dup_q       <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      cnt_q    <= cnt_d;
      dup_q    <= dup_d;
      // The valid marks die as soon as the scan ends, so a new scan starts clean.
      v1_q     <= issue;
      v2_q     <= v1_q && (state_q == dedd_pkg::BK_SCAN);
      v3_q     <= v2_q && (state_q == dedd_pkg::BK_SCAN);
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
      r2_q   <= {16'd0, radius_i} * {16'd0, radius_i};
    end
    for (int k = 0; k < 3; k++) begin
      ad_q[k] <= ad_d[k];
      sq_q[k] <= {16'd0, ad_q[k]} * {16'd0, ad_q[k]};
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  // Point table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[IDX_W-1:0]] <= item_q.pos;
    end
    if (issue) begin
      rdata_q <= mem[rd_idx_q[IDX_W-1:0]];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.stored_count, out_q.table_full, out_q.duplicate,
                          out_q.recorded, out_q.trapped};

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({out_q.recorded, out_q.duplicate, out_q.table_full}))
    else $error("more than one outcome flag set");

  a_rec_grows_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && rec) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("a stored point did not raise the count");

  a_full_only_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && full) |-> (cnt_q == CNT_W'(MAX_ENTRIES)))
    else $error("table reported full below its size");

  a_outcome_needs_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.trapped) |->
      !(out_q.recorded || out_q.duplicate || out_q.table_full))
    else $error("outcome flag without a dead end");

endmodule

`default_nettype wire

/* src/dead_end_detect_dedup_top.sv */
// Top level of the dead end detector with its deduplicating point table.
// Depends on dedd_pkg, dedd_front, dedd_fifo and dedd_back.
`timescale 1ns / 1ps
`default_nettype none

// Each input word gives three proximity readings and a position; one result word
// comes back for it. A word without a dead end goes from idle straight to emit in
// the back end; a dead end is scanned against the stored points, as the point table
// has one read port and the scan reads one point per cycle through a pipeline of
// read, absolute difference and square (it stops early on a match). A two-word
// queue sits between input classification and the scan, and the result register
// lets the next word be scanned while a result waits. Configuration writes must
// happen only while no word is in flight. No clearing pass is needed after reset.
module dead_end_detect_dedup_top #(
  parameter int MAX_ENTRIES = dedd_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dedd_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [dedd_pkg::PDATA_W-1:0]      pwdata,
  output logic      [dedd_pkg::PDATA_W-1:0]      prdata,
  output logic                                   pready,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // front_prox[11:0], left_prox[23:12], right_prox[35:24], pos_x[51:36],
  // pos_y[67:52], pos_z[83:68], zero pad[87:84]
  input  wire logic [dedd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // trapped[0], recorded[1], duplicate[2], table_full[3], stored_count[11:4],
  // zero pad[15:12]
  output logic      [dedd_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  logic                          q_full, q_empty, q_push, q_pop;
  dedd_pkg::item_t               q_in_item, q_out_item;
  logic [dedd_pkg::RADIUS_W-1:0] radius;

  dedd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in_item),
    .radius_o      (radius)
  );

  dedd_fifo #(
    .DEPTH (dedd_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_in_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_item_o  (q_out_item),
    .empty_o     (q_empty)
  );

  dedd_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .radius_i      (radius),
    .q_empty_i     (q_empty),
    .q_item_i      (q_out_item),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_dead_end_detect_dedup_top.sv */
// Self-checking testbench for dead_end_detect_dedup_top: sensor words in, result words out.
// Depends on dedd_pkg and the block itself; a local predictor keeps its own point table.
`timescale 1ns / 1ps

module tb_dead_end_detect_dedup_top;

  localparam int TABLE_DEPTH = dedd_pkg::MAX_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 160;

  typedef struct packed {
    logic        [dedd_pkg::PROX_W-1:0] front, left, right;
    logic signed [dedd_pkg::POS_W-1:0]  x, y, z;
  } sensor_word_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_TYPED,
    ROW_CONFIG
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    dedd_pkg::reg_idx_e idx;
    logic [15:0]        value;
    sensor_word_t       w;
    dedd_pkg::result_t  res;
  } row_t;

  localparam int N_ROWS = 24;

  // Typed results hold only at reset settings and at a glance; the rest go to the predictor.
  localparam row_t DIRECTED [N_ROWS] = '{
    '{ROW_TYPED, dedd_pkg::REG_NONE, 16'd0,
      '{12'd0, 12'd0, 12'd0, 16'sd0, 16'sd0, 16'sd0}, '{1'b0, 1'b0, 1'b0, 1'b0, 8'd0}},
    '{ROW_TYPED, dedd_pkg::REG_NONE, 16'd0,
      '{12'd80, 12'd51, 12'd51, 16'sd0, 16'sd0, 16'sd0}, '{1'b0, 1'b0, 1'b0, 1'b0, 8'd0}},
    '{ROW_TYPED, dedd_pkg::REG_NONE, 16'd0,
      '{12'd81, 12'd50, 12'd51, 16'sd0, 16'sd0, 16'sd0}, '{1'b0, 1'b0, 1'b0, 1'b0, 8'd0}},
    '{ROW_TYPED, dedd_pkg::REG_NONE, 16'd0,
      '{12'd81, 12'd51, 12'd50, 16'sd0, 16'sd0, 16'sd0}, '{1'b0, 1'b0, 1'b0, 1'b0, 8'd0}},
    '{ROW_TYPED, dedd_pkg::REG_NONE, 16'd0,
      '{12'd81, 12'd51, 12'd51, 16'sd0, 16'sd0, 16'sd0}, '{1'b1, 1'b1, 1'b0, 1'b0, 8'd1}},
    '{ROW_TYPED, dedd_pkg::REG_NONE, 16'd0,
      '{12'd4095, 12'd4095, 12'd4095, 16'sd0, 16'sd0, 16'sd0},
      '{1'b1, 1'b0, 1'b1, 1'b0, 8'd1}},
    '{ROW_PREDICT, dedd_pkg::REG_NONE, 16'd0,
      '{12'd81, 12'd51, 12'd51, 16'sd99, 16'sd0, 16'sd0}, '0},
    '{ROW_PREDICT, dedd_pkg::REG_NONE, 16'd0,
      '{12'd81, 12'd51, 12'd51, 16'sd100, 16'sd0, 16'sd0}, '0},
    '{ROW_TYPED, dedd_pkg::REG_NONE, 16'd0,
      '{12'd4095, 12'd4095, 12'd4095, 16'sh8000, 16'sh8000, 16'sh8000},
      '{1'b1, 1'b1, 1'b0, 1'b0, 8'd3}},
    '{ROW_TYPED, dedd_pkg::REG_NONE, 16'd0,
      '{12'd4095, 12'd4095, 12'd4095, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
      '{1'b1, 1'b1, 1'b0, 1'b0, 8'd4}},
    '{ROW_PREDICT, dedd_pkg::REG_NONE, 16'd0,
      '{12'd300, 12'd200, 12'd100, 16'sh7FFF, 16'sh7FC6, 16'sh7FC6}, '0},
    '{ROW_PREDICT, dedd_pkg::REG_NONE, 16'd0,
      '{12'd82, 12'd52, 12'd52, 16'sd60, 16'sd80, 16'sd0}, '0},
    '{ROW_TYPED, dedd_pkg::REG_NONE, 16'd0,
      '{12'd4095, 12'd0, 12'd4095, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
      '{1'b0, 1'b0, 1'b0, 1'b0, 8'd4}},
    '{ROW_PREDICT, dedd_pkg::REG_NONE, 16'd0,
      '{12'hAAA, 12'h555, 12'hAAA, 16'sh5555, 16'shAAAA, 16'sh1234}, '0},
    '{ROW_CONFIG, dedd_pkg::REG_RADIUS, 16'd0, '0, '0},
    '{ROW_PREDICT, dedd_pkg::REG_NONE, 16'd0,
      '{12'd81, 12'd51, 12'd51, 16'sd0, 16'sd0, 16'sd0}, '0},
    '{ROW_CONFIG, dedd_pkg::REG_RADIUS, 16'd65535, '0, '0},
    '{ROW_PREDICT, dedd_pkg::REG_NONE, 16'd0,
      '{12'd81, 12'd51, 12'd51, 16'sd1000, 16'shFC18, 16'sd500}, '0},
    '{ROW_CONFIG, dedd_pkg::REG_FRONT_THR, 16'd4095, '0, '0},
    '{ROW_PREDICT, dedd_pkg::REG_NONE, 16'd0,
      '{12'd4095, 12'd4095, 12'd4095, 16'sd123, 16'sd456, 16'sd789}, '0},
    '{ROW_CONFIG, dedd_pkg::REG_FRONT_THR, 16'd0, '0, '0},
    '{ROW_CONFIG, dedd_pkg::REG_SIDE_THR, 16'd0, '0, '0},
    '{ROW_PREDICT, dedd_pkg::REG_NONE, 16'd0,
      '{12'd1, 12'd1, 12'd1, 16'sh0FF0, 16'shF00F, 16'sh00FF}, '0},
    '{ROW_PREDICT, dedd_pkg::REG_NONE, 16'd0,
      '{12'd1, 12'd0, 12'd1, 16'sh0FF0, 16'shF00F, 16'sh00FF}, '0}
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            psel, penable, pwrite, pready;
  logic [dedd_pkg::PADDR_W-1:0]    paddr;
  logic [dedd_pkg::PDATA_W-1:0]    pwdata, prdata;
  logic                            s_axis_tvalid, s_axis_tready;
  logic [dedd_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                            m_axis_tvalid, m_axis_tready;
  logic [dedd_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // Predictor state: its own copy of the settings and of the point table.
  logic [dedd_pkg::PROX_W-1:0]   thr_front = dedd_pkg::FRONT_THR_RST;
  logic [dedd_pkg::PROX_W-1:0]   thr_side  = dedd_pkg::SIDE_THR_RST;
  logic [dedd_pkg::RADIUS_W-1:0] radius_mm = dedd_pkg::RADIUS_RST;
  dedd_pkg::point_t              seen_pts [TABLE_DEPTH];
  int                            seen_count = 0;

  dedd_pkg::result_t awaited_results [$];
  int      errors = 0;
  int      cycle_count = 0;
  int      n_words = 0, n_dead = 0, n_stored = 0, n_dup = 0, n_full = 0, n_writes = 0;
  int      send_stretch = 0;
  bit      send_idle;

  dead_end_detect_dedup_top #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Classifies one word and, on a dead end, looks it up in the table and stores it if new and the table has room.
  function automatic dedd_pkg::result_t predict_outcome(sensor_word_t w);
    dedd_pkg::result_t r;
    longint  dx, dy, dz, r2;
    bit      hit;
    int      i;
    r = '0;
    hit = 1'b0;
    r.trapped = (w.front > thr_front) && (w.left > thr_side) && (w.right > thr_side);
    if (r.trapped) begin
      n_dead++;
      r2 = longint'(radius_mm) * longint'(radius_mm);
      for (i = 0; i < seen_count; i++) begin
        dx = longint'($signed(w.x)) - longint'($signed(seen_pts[i].x));
        dy = longint'($signed(w.y)) - longint'($signed(seen_pts[i].y));
        dz = longint'($signed(w.z)) - longint'($signed(seen_pts[i].z));
        if (dx * dx + dy * dy + dz * dz < r2) hit = 1'b1;
      end
      if (hit) begin
        r.duplicate = 1'b1;
        n_dup++;
      end else if (seen_count < TABLE_DEPTH) begin
        seen_pts[seen_count] = '{x: w.x, y: w.y, z: w.z};
        seen_count++;
        r.recorded = 1'b1;
        n_stored++;
      end else begin
        r.table_full = 1'b1;
        n_full++;
      end
    end
    r.stored_count = dedd_pkg::COUNT_W'(seen_count);
    return r;
  endfunction

  // A reading that counts as a wall against the given threshold, where one exists.
  function automatic logic [dedd_pkg::PROX_W-1:0] wall_level(
    logic [dedd_pkg::PROX_W-1:0] thr
  );
    if (thr == 12'hFFF) return dedd_pkg::PROX_W'($urandom_range(0, 4095));
    return dedd_pkg::PROX_W'($urandom_range(int'(thr) + 1, 4095));
  endfunction

  // Mostly complete dead ends, some with one wall missing, a few pure noise; positions are
  // either fresh or close to a stored point so that duplicates come up often.
  function automatic sensor_word_t random_reading();
    sensor_word_t     w;
    dedd_pkg::point_t pt;
    int               pick, spread;
    pick = $urandom_range(0, 99);
    w.front = wall_level(thr_front);
    w.left  = wall_level(thr_side);
    w.right = wall_level(thr_side);
    if (pick >= 65 && pick < 85) begin
      case ($urandom_range(0, 2))
        0:       w.front = dedd_pkg::PROX_W'($urandom_range(0, int'(thr_front)));
        1:       w.left  = dedd_pkg::PROX_W'($urandom_range(0, int'(thr_side)));
        default: w.right = dedd_pkg::PROX_W'($urandom_range(0, int'(thr_side)));
      endcase
    end else if (pick >= 85) begin
      w.front = dedd_pkg::PROX_W'($urandom);
      w.left  = dedd_pkg::PROX_W'($urandom);
      w.right = dedd_pkg::PROX_W'($urandom);
    end
    if (seen_count > 0 && $urandom_range(0, 99) < 45) begin
      pt = seen_pts[$urandom_range(0, seen_count - 1)];
      spread = (radius_mm > 2000) ? 2000 : ((radius_mm == 0) ? 4 : int'(radius_mm));
      w.x = pt.x + dedd_pkg::POS_W'(int'($urandom_range(0, 2 * spread)) - spread);
      w.y = pt.y + dedd_pkg::POS_W'(int'($urandom_range(0, 2 * spread)) - spread);
      w.z = pt.z + dedd_pkg::POS_W'(int'($urandom_range(0, 2 * spread)) - spread);
    end else begin
      w.x = dedd_pkg::POS_W'($urandom);
      w.y = dedd_pkg::POS_W'($urandom);
      w.z = dedd_pkg::POS_W'($urandom);
    end
    return w;
  endfunction

  // Presents one word after a random gap and returns once it has been taken.
  task automatic push_word(sensor_word_t w, bit use_typed, dedd_pkg::result_t typed_res);
    int                gap;
    dedd_pkg::result_t r;
    if (send_stretch == 0) begin
      send_idle = 1'($urandom_range(0, 1));
      send_stretch = $urandom_range(10, 50);
    end
    send_stretch--;
    gap = send_idle ? $urandom_range(0, 10) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    r = predict_outcome(w);
    awaited_results.push_back(use_typed ? typed_res : r);
    n_words++;
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {4'b0, w.z, w.y, w.x, w.right, w.left, w.front};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes a register with junk above its width, then reads it back.
  task automatic program_reg(dedd_pkg::reg_idx_e idx, logic [15:0] value);
    logic [dedd_pkg::PDATA_W-1:0] wr, rd_want;
    wr = $urandom;
    if (idx == dedd_pkg::REG_RADIUS) begin
      wr[15:0] = value;
      rd_want = {16'b0, value};
      radius_mm = value;
    end else begin
      wr[11:0] = value[11:0];
      rd_want = {20'b0, value[11:0]};
      if (idx == dedd_pkg::REG_FRONT_THR) thr_front = value[11:0];
      else thr_side = value[11:0];
    end
    n_writes++;
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = wr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== rd_want) begin
      $error("prdata of register %s: expected %0h, got %0h", idx.name(), rd_want, prdata);
      errors++;
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Result side: random stalls, then each word is checked against the oldest expectation.
  initial begin
    int                stall, stretch;
    bit                stall_on;
    dedd_pkg::result_t want, got;
    m_axis_tready = 1'b0;
    stretch = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (stretch == 0) begin
        stall_on = 1'($urandom_range(0, 1));
        stretch = $urandom_range(10, 50);
      end
      stretch--;
      stall = stall_on ? $urandom_range(0, 10) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.trapped      = m_axis_tdata[0];
      got.recorded     = m_axis_tdata[1];
      got.duplicate    = m_axis_tdata[2];
      got.table_full   = m_axis_tdata[3];
      got.stored_count = m_axis_tdata[11:4];
      if (awaited_results.size() == 0) begin
        $error("result word %0h arrived with nothing outstanding", m_axis_tdata);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (got.trapped !== want.trapped) begin
          $error("dead end flag: expected %0b, got %0b", want.trapped, got.trapped);
          errors++;
        end
        if (got.recorded !== want.recorded) begin
          $error("recorded: expected %0b, got %0b", want.recorded, got.recorded);
          errors++;
        end
        if (got.duplicate !== want.duplicate) begin
          $error("duplicate: expected %0b, got %0b", want.duplicate, got.duplicate);
          errors++;
        end
        if (got.table_full !== want.table_full) begin
          $error("table_full: expected %0b, got %0b", want.table_full, got.table_full);
          errors++;
        end
        if (got.stored_count !== want.stored_count) begin
          $error("stored_count: expected %0d, got %0d", want.stored_count, got.stored_count);
          errors++;
        end
      end
    end
  end

  initial begin
    int          k, p, n;
    logic [15:0] f_thr, s_thr, rad;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (k = 0; k < N_ROWS; k++) begin
      if (DIRECTED[k].kind == ROW_CONFIG) begin
        drain_results();
        program_reg(DIRECTED[k].idx, DIRECTED[k].value);
      end else begin
        push_word(DIRECTED[k].w, DIRECTED[k].kind == ROW_TYPED, DIRECTED[k].res);
      end
    end

    // Random phases; the zero-radius one fills the table so later dead ends find it full.
    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin f_thr = 16'd80;   s_thr = 16'd50;   rad = 16'd100;   n = 150; end
        1: begin f_thr = 16'd200;  s_thr = 16'd300;  rad = 16'd65535; n = 70;  end
        2: begin f_thr = 16'd1000; s_thr = 16'd1000; rad = 16'd0;     n = 80;  end
        3: begin
          f_thr = 16'd0;
          s_thr = 16'd0;
          rad = 16'($urandom_range(1, 500));
          n = 100;
        end
        4: begin
          f_thr = 16'd4095;
          s_thr = 16'($urandom_range(0, 4095));
          rad = 16'($urandom);
          n = 30;
        end
        default: begin
          f_thr = 16'($urandom_range(0, 3000));
          s_thr = 16'($urandom_range(0, 3000));
          rad = 16'($urandom_range(1, 3000));
          n = 270;
        end
      endcase
      drain_results();
      program_reg(dedd_pkg::REG_FRONT_THR, f_thr);
      program_reg(dedd_pkg::REG_SIDE_THR, s_thr);
      program_reg(dedd_pkg::REG_RADIUS, rad);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 59) == 0) drain_results();
        push_word(random_reading(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d words in %0d cycles: %0d dead ends, %0d stored, %0d duplicates,",
             n_words, cycle_count, n_dead, n_stored, n_dup);
    $display("%0d refused; made %0d register writes, covering zero and full-scale settings.",
             n_full, n_writes);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
